// File: design/dhf_pkg.sv
package dhf_pkg;

    // configuration register map
    localparam int                 CFG_INDEX_BITS   = 1;
    localparam int                 CFG_DATA_BITS    = 16;
    localparam int                 FW_BITS          = 12;
    localparam int                 FH_BITS          = 16;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_HEIGHT = 1'd1;
    localparam logic [FW_BITS-1:0] FRAME_WIDTH_RESET  = 12'd640;
    localparam logic [FH_BITS-1:0] FRAME_HEIGHT_RESET = 16'd480;

    // floor(s / 3) == (s * 683) >> 11 for every s up to 1020
    localparam logic [10:0]        RECIP3       = 11'd683;
    localparam int                 RECIP3_SHIFT = 11;

    // blue in the low byte
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_CALC
    } state_t;

endpackage

// File: design/dhf_ram.sv
module dhf_ram #(
    parameter int DEPTH = 2048,
    parameter int DW    = 24
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DW-1:0]            wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr0,
    input  logic [$clog2(DEPTH)-1:0] raddr1,
    output logic [DW-1:0]            rdata0,
    output logic [DW-1:0]            rdata1
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read, data held until the next read
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata0 <= mem[raddr0];
            rdata1 <= mem[raddr1];
        end
    end

endmodule

// File: design/dhf_avg.sv
module dhf_avg import dhf_pkg::*; (
    input  pixel_t up_left,
    input  pixel_t up_right,
    input  pixel_t low_left,
    input  pixel_t low_right,
    output pixel_t avg
);

    pixel_t      nb [4];
    logic [2:0]  cnt;
    logic [9:0]  sum  [3];
    logic [20:0] prod [3];
    logic [7:0]  quot [3];

    assign nb[0] = up_left;
    assign nb[1] = up_right;
    assign nb[2] = low_left;
    assign nb[3] = low_right;

    // black neighbors take no part in the average
    always_comb begin
        cnt = '0;
        for (int i = 0; i < 4; i++) begin
            cnt = cnt + 3'((nb[i] != '0) ? 1 : 0);
        end
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            sum[c] = '0;
            for (int i = 0; i < 4; i++) begin
                if (nb[i] != '0) begin
                    sum[c] = sum[c] + 10'(nb[i][8*c +: 8]);
                end
            end
            prod[c] = 21'(sum[c]) * 21'(RECIP3);
            case (cnt)
                3'd1:    quot[c] = sum[c][7:0];
                3'd2:    quot[c] = sum[c][8:1];
                3'd3:    quot[c] = prod[c][RECIP3_SHIFT +: 8];
                3'd4:    quot[c] = sum[c][9:2];
                default: quot[c] = '0;
            endcase
        end
    end

    assign avg = pixel_t'({quot[2], quot[1], quot[0]});

endmodule

// File: design/diagonal_hole_fill.sv
// channel   dir  payload                                  marker
// s_axis    in   tdata: blue, green, red (8 bits each)    tuser: flush item
// m_axis    out  tdata: blue, green, red (8 bits each)    tlast: last pixel of frame
// cfg       in   cfg_index 0 = frame width, 1 = frame height
//
// one input transaction at a time: the accept cycle issues the line memory reads,
// the compute state takes the registered read data, computes the fill and writes back
// results lag the input by one row plus one pixel; flush items drain the tail
// the result register lets a new transaction in while the previous result waits;
// the compute cycle stalls only while that register is still full
// reset is synchronous, active low; line memories need no clearing pass
module diagonal_hole_fill import dhf_pkg::*; #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    // configuration
    input  logic                      cfg_wr_en,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_wdata,
    // input pixels
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [23:0]               s_tdata,   // pixel_blue, pixel_green, pixel_red
    input  logic [0:0]                s_tuser,   // flush_item
    // filled pixels
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [23:0]               m_tdata,   // out_blue, out_green, out_red
    output logic                      m_tlast    // frame_end
);

    localparam int WW = $clog2(MAX_WIDTH + 1);   // column, pointer and width
    localparam int XW = $clog2(MAX_WIDTH);       // filled row address
    localparam int EW = (WW > FW_BITS) ? WW : FW_BITS;

    // configuration registers
    logic [FW_BITS-1:0] frame_width_reg;
    logic [FH_BITS-1:0] frame_height_reg;

    // effective frame size: zero means one, width saturates at the line length
    logic [EW-1:0]      fw_ext;
    logic [EW-1:0]      w_eff_ext;
    logic [WW-1:0]      w_eff;
    logic [FH_BITS-1:0] h_eff;

    assign fw_ext    = EW'(frame_width_reg);
    assign w_eff_ext = (fw_ext == '0) ? EW'(1) :
                       (fw_ext > EW'(MAX_WIDTH)) ? EW'(MAX_WIDTH) : fw_ext;
    assign w_eff     = w_eff_ext[WW-1:0];
    assign h_eff     = (frame_height_reg == '0) ? FH_BITS'(1) : frame_height_reg;

    // control state
    state_t             state_reg, state_next;
    logic [WW-1:0]      in_col_reg, in_col_next;
    logic [FH_BITS-1:0] in_row_reg, in_row_next;
    logic [WW-1:0]      wr_ptr_reg, wr_ptr_next;     // pending store slot of next input
    logic [WW-1:0]      out_x_reg, out_x_next;
    logic [FH_BITS-1:0] out_y_reg, out_y_next;
    logic [WW-1:0]      out_ptr_reg, out_ptr_next;   // pending store slot of next output
    logic               emit_reg;                    // item in flight makes a result
    logic               wpix_reg;                    // item in flight is stored
    logic               m_valid_reg;

    // payload
    logic [WW-1:0]      wr_addr_reg;
    pixel_t             lr_reg;                      // lower right neighbor, the new pixel
    pixel_t             hold_reg, hold_next;         // upper left neighbor, already filled
    pixel_t             m_data_reg;
    logic               m_last_reg;

    // handshake
    logic               accept;
    logic               is_flush;
    logic               row_live;
    logic               pix_emit;
    logic               item_emit;
    logic               item_wr;
    logic               out_free;
    logic               calc_go;
    logic               emit_go;

    assign accept   = s_tvalid && s_tready;
    assign is_flush = s_tuser[0];
    assign row_live = in_row_reg < h_eff;
    // input position at least one row plus one pixel in
    assign pix_emit = (in_row_reg >= FH_BITS'(2)) ||
                      ((in_row_reg == FH_BITS'(1)) && (in_col_reg != '0));
    // a pixel past the frame and a flush before its end are dropped
    assign item_emit = is_flush ? !row_live : (row_live && pix_emit);
    assign item_wr   = !is_flush && row_live;

    assign out_free = !m_valid_reg || m_tready;
    assign calc_go  = (state_reg == ST_CALC) && (!emit_reg || out_free);
    assign emit_go  = calc_go && emit_reg;

    // memory addresses; output counters advance in the compute cycle, input counters at accept
    logic [WW-1:0] ll_addr;
    logic [WW-1:0] x_plus1;

    assign ll_addr = (out_ptr_reg >= WW'(2)) ? (out_ptr_reg - WW'(2))
                                             : (out_ptr_reg + w_eff - WW'(1));
    assign x_plus1 = out_x_reg + WW'(1);

    pixel_t pend_center, pend_ll;
    pixel_t fill_ul, fill_ur;
    pixel_t avg;
    pixel_t result;

    // received pixels still waiting for output, one row plus one deep
    dhf_ram #(
        .DEPTH (MAX_WIDTH + 1),
        .DW    (24)
    ) u_pending (
        .aclk   (aclk),
        .we     (calc_go && wpix_reg),
        .waddr  (wr_addr_reg),
        .wdata  (lr_reg),
        .re     (accept),
        .raddr0 (out_ptr_reg),
        .raddr1 (ll_addr),
        .rdata0 (pend_center),
        .rdata1 (pend_ll)
    );

    // filled pixels of the row above the output position
    dhf_ram #(
        .DEPTH (MAX_WIDTH),
        .DW    (24)
    ) u_filled (
        .aclk   (aclk),
        .we     (emit_go),
        .waddr  (out_x_reg[XW-1:0]),
        .wdata  (result),
        .re     (accept),
        .raddr0 (out_x_reg[XW-1:0]),
        .raddr1 (x_plus1[XW-1:0]),
        .rdata0 (fill_ul),
        .rdata1 (fill_ur)
    );

    dhf_avg u_avg (
        .up_left   (hold_reg),
        .up_right  (fill_ur),
        .low_left  (pend_ll),
        .low_right (lr_reg),
        .avg       (avg)
    );

    // output position classification
    logic interior;
    logic is_last;

    assign interior = (out_y_reg != '0) &&
                      ((17'(out_y_reg) + 17'd1) < 17'(h_eff)) &&
                      (out_x_reg != '0) &&
                      ((out_x_reg + WW'(1)) < w_eff);
    assign is_last  = (out_x_reg == (w_eff - WW'(1))) &&
                      (out_y_reg == (h_eff - FH_BITS'(1)));

    // only an interior black pixel is filled; all-black neighbors leave it black
    assign result = (interior && (pend_center == '0)) ? avg : pend_center;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC: begin
                if (calc_go) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        s_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE: s_tready = 1'b1;
            ST_CALC: s_tready = 1'b0;
            default: s_tready = 1'b0;
        endcase
    end

    // position counters
    always_comb begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        wr_ptr_next  = wr_ptr_reg;
        out_x_next   = out_x_reg;
        out_y_next   = out_y_reg;
        out_ptr_next = out_ptr_reg;
        hold_next    = hold_reg;

        if (accept && item_wr) begin
            if ((in_col_reg + WW'(1)) >= w_eff) begin
                in_col_next = '0;
                in_row_next = in_row_reg + FH_BITS'(1);
            end else begin
                in_col_next = in_col_reg + WW'(1);
            end
            wr_ptr_next = (wr_ptr_reg == w_eff) ? '0 : (wr_ptr_reg + WW'(1));
        end

        if (emit_go) begin
            hold_next = fill_ul;
            if (is_last) begin
                // frame drained, next pixel starts a new frame
                in_col_next  = '0;
                in_row_next  = '0;
                wr_ptr_next  = '0;
                out_x_next   = '0;
                out_y_next   = '0;
                out_ptr_next = '0;
                hold_next    = '0;
            end else begin
                if ((out_x_reg + WW'(1)) >= w_eff) begin
                    out_x_next = '0;
                    out_y_next = out_y_reg + FH_BITS'(1);
                end else begin
                    out_x_next = out_x_reg + WW'(1);
                end
                out_ptr_next = (out_ptr_reg == w_eff) ? '0 : (out_ptr_reg + WW'(1));
            end
        end

        // any register write restarts the frame
        if (cfg_wr_en) begin
            in_col_next  = '0;
            in_row_next  = '0;
            wr_ptr_next  = '0;
            out_x_next   = '0;
            out_y_next   = '0;
            out_ptr_next = '0;
            hold_next    = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            frame_width_reg  <= FRAME_WIDTH_RESET;
            frame_height_reg <= FRAME_HEIGHT_RESET;
            in_col_reg       <= '0;
            in_row_reg       <= '0;
            wr_ptr_reg       <= '0;
            out_x_reg        <= '0;
            out_y_reg        <= '0;
            out_ptr_reg      <= '0;
            emit_reg         <= 1'b0;
            wpix_reg         <= 1'b0;
            m_valid_reg      <= 1'b0;
            hold_reg         <= '0;
        end else begin
            state_reg   <= state_next;
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            wr_ptr_reg  <= wr_ptr_next;
            out_x_reg   <= out_x_next;
            out_y_reg   <= out_y_next;
            out_ptr_reg <= out_ptr_next;
            hold_reg    <= hold_next;

            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_FRAME_WIDTH:  frame_width_reg  <= cfg_wdata[FW_BITS-1:0];
                    REG_FRAME_HEIGHT: frame_height_reg <= cfg_wdata[FH_BITS-1:0];
                    default: ;
                endcase
            end

            if (accept) begin
                emit_reg <= item_emit;
                wpix_reg <= item_wr;
            end

            if (emit_go) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // item payload captured at the accept edge
    always_ff @(posedge aclk) begin
        if (accept) begin
            lr_reg      <= is_flush ? pixel_t'('0) : pixel_t'(s_tdata);
            wr_addr_reg <= wr_ptr_reg;
        end
        if (emit_go) begin
            m_data_reg <= result;
            m_last_reg <= is_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule

// File: design/dhf_checker.sv
module dhf_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tlast
);

    // a stalled result holds its data and marker
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("result changed while stalled");

    // one transaction at a time: no accept right after an accept
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken during compute cycle");

    // a new result only appears out of the compute cycle
    a_result_from_calc: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result without a compute cycle");

    // reset empties the result register
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind diagonal_hole_fill dhf_checker u_dhf_checker (.*);

// File: test/tb_diagonal_hole_fill.sv
`timescale 1ns / 100ps

module tb_diagonal_hole_fill;
    import dhf_pkg::*;

    localparam int LINE_MAX     = 2048;
    localparam int TX_IDLE_MAX  = 14;
    localparam int RX_IDLE_MAX  = 14;
    localparam int LONG_HOLD    = 400;      // receiver hold-off, long enough to back up the input
    localparam int HOLD_EVERY   = 300;      // results between long hold-offs
    localparam int DRAIN_CYCLES = 24;       // covers the accept and compute steps plus the result register
    localparam int RANDOM_ITEMS = 800;
    localparam int RUN_LIMIT    = 1_000_000;

    // one input transaction and one filled pixel
    typedef struct {
        pixel_t pix;
        logic   flush;
    } stream_item_t;

    typedef struct {
        pixel_t pix;
        logic   last;
    } fill_result_t;

    logic                      aclk      = 1'b0;
    logic                      aresetn   = 1'b0;
    logic                      cfg_wr_en = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_wdata = '0;
    logic                      s_tvalid  = 1'b0;
    logic                      s_tready;
    logic [23:0]               s_tdata   = '0;   // pixel_blue, pixel_green, pixel_red
    logic [0:0]                s_tuser   = '0;   // flush_item
    logic                      m_tvalid;
    logic                      m_tready  = 1'b0;
    logic [23:0]               m_tdata;          // out_blue, out_green, out_red
    logic                      m_tlast;          // frame_end

    diagonal_hole_fill #(
        .MAX_WIDTH(LINE_MAX)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #6 aclk = ~aclk;

    // stimulus and expected results
    stream_item_t pixel_stream[$];
    fill_result_t filled_due[$];

    // pacing controls, changed between phases
    bit          tx_pace = 1'b1;
    bit          rx_pace = 1'b1;
    int unsigned tx_wait;
    int unsigned rx_wait;
    int unsigned results_seen;
    int unsigned fail_count;
    int unsigned cycle_count;

    // predictor state: registers, line of filled pixels, pixels awaiting output
    logic [FW_BITS-1:0] fill_width;
    logic [FH_BITS-1:0] fill_height;
    pixel_t             line_store [LINE_MAX];
    pixel_t             held_pixels [LINE_MAX+1];
    int unsigned        in_col;
    int unsigned        in_row;
    int unsigned        out_pos;
    pixel_t             upper_left;

    // 4x3 frame: one hole with all diagonals black, one hole with three live diagonals
    logic [23:0] demo_frame [12] = '{
        24'h000000, 24'hFFFFFF, 24'h000000, 24'h0000FF,
        24'h808080, 24'h000000, 24'h000000, 24'h000000,
        24'h000000, 24'h000000, 24'h000000, 24'hFF0000
    };

    // ------------------------------------------------------------------
    // reference predictor
    // ------------------------------------------------------------------

    // width 0 acts as 1, anything past the line store saturates
    function automatic int unsigned fill_cols();
        int unsigned w;
        w = fill_width;
        if (w == 0) w = 1;
        if (w > LINE_MAX) w = LINE_MAX;
        return w;
    endfunction

    function automatic int unsigned fill_rows();
        return (fill_height == 0) ? 1 : fill_height;
    endfunction

    function automatic void hole_fill_restart();
        in_col     = 0;
        in_row     = 0;
        out_pos    = 0;
        upper_left = '0;
    endfunction

    function automatic void hole_fill_config(logic [CFG_INDEX_BITS-1:0] idx,
                                             logic [CFG_DATA_BITS-1:0] val);
        if (idx == REG_FRAME_WIDTH)
            fill_width = val[FW_BITS-1:0];
        else
            fill_height = val[FH_BITS-1:0];
        hole_fill_restart();
    endfunction

    // produce the pixel at out_pos; lower_right is the pixel arriving now
    function automatic void hole_fill_emit(pixel_t lower_right);
        int unsigned w, h, total, o, x, y, cnt, sum_b, sum_g, sum_r;
        pixel_t      center, result;
        pixel_t      nb [4];
        bit          inner;
        fill_result_t due;
        w      = fill_cols();
        h      = fill_rows();
        total  = w * h;
        o      = out_pos;
        y      = o / w;
        x      = o % w;
        center = held_pixels[o % (w + 1)];
        inner  = y >= 1 && y + 1 < h && x >= 1 && x + 1 < w;
        result = center;
        if (inner && center == '0) begin
            // upper diagonals already filled, lower ones as received
            nb[0] = upper_left;
            nb[1] = line_store[x + 1];
            nb[2] = held_pixels[(o + w - 1) % (w + 1)];
            nb[3] = lower_right;
            cnt   = 0;
            sum_b = 0;
            sum_g = 0;
            sum_r = 0;
            foreach (nb[i]) begin
                if (nb[i] != '0) begin
                    cnt++;
                    sum_b += nb[i].blue;
                    sum_g += nb[i].green;
                    sum_r += nb[i].red;
                end
            end
            // no live neighbor: the hole stays black
            if (cnt != 0) begin
                result.blue  = 8'(sum_b / cnt);
                result.green = 8'(sum_g / cnt);
                result.red   = 8'(sum_r / cnt);
            end
        end
        upper_left    = line_store[x];
        line_store[x] = result;
        due.pix  = result;
        due.last = (o + 1 == total);
        filled_due.insert(filled_due.size(), due);
        out_pos = (o + 1) & 32'h07FF_FFFF;
        if (o + 1 >= total) hole_fill_restart();
    endfunction

    function automatic void hole_fill_step(stream_item_t item);
        int unsigned w, h, pos;
        bit          emitted;
        w       = fill_cols();
        h       = fill_rows();
        pos     = in_row * w + in_col;
        emitted = 1'b0;
        if (!item.flush) begin
            // pixels past the end of the frame are dropped until it drains
            if (in_row < h) begin
                if (pos >= w + 1) begin
                    hole_fill_emit(item.pix);
                    emitted = 1'b1;
                end
                held_pixels[pos % (w + 1)] = item.pix;
                if (!emitted || out_pos != 0) begin
                    in_col++;
                    if (in_col >= w) begin
                        in_col = 0;
                        in_row++;
                    end
                end
            end
        end else if (in_row >= h) begin
            // flush only counts once the whole frame is in
            hole_fill_emit('0);
        end
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    function automatic void queue_item(pixel_t pix, logic flush);
        stream_item_t item;
        item.pix   = pix;
        item.flush = flush;
        pixel_stream.insert(pixel_stream.size(), item);
    endfunction

    // plenty of holes, saturated pixels and single-channel pixels
    function automatic pixel_t random_pixel();
        pixel_t p;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: p = '0;
            4: p = '1;
            5: begin
                p = '0;
                p[8 * $urandom_range(0, 2) +: 8] = 8'($urandom_range(1, 255));
            end
            default: p = 24'($urandom());
        endcase
        return p;
    endfunction

    // queues cut pixels of a frame at the current size, plus the drain flushes if complete;
    // noisy adds a stray flush mid-frame, a stray pixel mid-drain and one flush after it
    function automatic int unsigned queue_frame(int unsigned cut, bit noisy);
        int unsigned w, h, px, drain, stray_flush, stray_pixel;
        w           = fill_cols();
        h           = fill_rows();
        px          = w * h;
        drain       = (px < w + 1) ? px : w + 1;
        stray_flush = (noisy && cut != 0) ? $urandom_range(0, cut - 1) : cut;
        stray_pixel = noisy ? $urandom_range(0, drain - 1) : drain;
        for (int unsigned i = 0; i < cut; i++) begin
            if (i == stray_flush) queue_item(24'($urandom()), 1'b1);
            queue_item(random_pixel(), 1'b0);
        end
        if (cut < px) return cut;
        for (int unsigned j = 0; j < drain; j++) begin
            if (j == stray_pixel) queue_item(random_pixel(), 1'b0);
            queue_item(24'($urandom()), 1'b1);
        end
        if (noisy) queue_item(24'($urandom()), 1'b1);
        return cut + drain;
    endfunction

    // block idle: all items in, all results out, pipe empty
    task automatic wait_idle();
        while (pixel_stream.size() != 0 || filled_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic cfg_write(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        hole_fill_config(idx, val);
    endtask

    function automatic bit log_failure();
        fail_count++;
        return fail_count <= 10;
    endfunction

    // ------------------------------------------------------------------
    // input driver: one transaction per handshake, random gap after each
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        bit offering;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
            tx_wait   = 0;
        end else begin
            offering = s_tvalid && !s_tready;
            if (s_tvalid && s_tready) begin
                hole_fill_step(pixel_stream.pop_front());
                tx_wait = tx_pace ? $urandom_range(0, TX_IDLE_MAX) : 0;
            end else if (!s_tvalid && tx_wait != 0) begin
                tx_wait--;
            end
            // a held offer keeps its data; otherwise present the next item or idle
            if (!offering) begin
                if (tx_wait == 0 && pixel_stream.size() != 0) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pixel_stream[0].pix;
                    s_tuser  <= pixel_stream[0].flush;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // result monitor and receiver back-pressure
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        fill_result_t want;
        pixel_t       got;
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_wait   = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                results_seen++;
                if (filled_due.size() == 0) begin
                    if (log_failure())
                        $display("result %0d with nothing expected: b=%0d g=%0d r=%0d last=%0b",
                                 results_seen, got.blue, got.green, got.red, m_tlast);
                end else begin
                    want = filled_due.pop_front();
                    if (got.blue !== want.pix.blue || got.green !== want.pix.green ||
                        got.red !== want.pix.red || m_tlast !== want.last) begin
                        if (log_failure())
                            $display("result %0d mismatch: expected %h last=%0b, got %h last=%0b",
                                     results_seen, want.pix, want.last, got, m_tlast);
                    end
                end
                // now and then a long hold-off so the input side backs up
                if (results_seen % HOLD_EVERY == HOLD_EVERY / 2)
                    rx_wait = LONG_HOLD;
                else
                    rx_wait = rx_pace ? $urandom_range(0, RX_IDLE_MAX) : 0;
                m_tready <= (rx_wait == 0);
            end else if (!m_tready) begin
                if (rx_wait != 0) rx_wait--;
                m_tready <= (rx_wait == 0);
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("[diagonal_hole_fill] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial begin
        int unsigned random_count, px, cut;
        bit          must_write;

        foreach (line_store[i]) line_store[i] = '0;
        foreach (held_pixels[i]) held_pixels[i] = '0;
        fill_width  = FRAME_WIDTH_RESET;
        fill_height = FRAME_HEIGHT_RESET;
        hole_fill_restart();

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // directed 4x3 frame: early flush dropped, stray pixel during drain dropped
        cfg_write(REG_FRAME_WIDTH, 16'd4);
        cfg_write(REG_FRAME_HEIGHT, 16'd3);
        queue_item('0, 1'b1);
        foreach (demo_frame[i]) queue_item(demo_frame[i], 1'b0);
        queue_item('0, 1'b1);
        queue_item('1, 1'b1);
        queue_item('1, 1'b0);
        repeat (3) queue_item('0, 1'b1);
        wait_idle();

        // zero width acts as one column, zero height as one row
        cfg_write(REG_FRAME_WIDTH, 16'd0);
        cfg_write(REG_FRAME_HEIGHT, 16'd5);
        void'(queue_frame(fill_cols() * fill_rows(), 1'b0));
        wait_idle();
        cfg_write(REG_FRAME_WIDTH, 16'd7);
        cfg_write(REG_FRAME_HEIGHT, 16'd0);
        void'(queue_frame(fill_cols() * fill_rows(), 1'b1));

        // random small frames, back to back, some cut short and abandoned
        random_count = 0;
        must_write   = 1'b1;
        while (random_count < RANDOM_ITEMS) begin
            if (must_write || $urandom_range(0, 2) == 0) begin
                wait_idle();
                case ($urandom_range(0, 2))
                    0: begin
                        cfg_write(REG_FRAME_WIDTH,
                                  16'(($urandom_range(0, 7) == 0) ?
                                      $urandom_range(11, 40) : $urandom_range(0, 10)));
                        cfg_write(REG_FRAME_HEIGHT, 16'($urandom_range(0, 8)));
                    end
                    1: cfg_write(REG_FRAME_WIDTH, 16'($urandom_range(0, 12)));
                    default: cfg_write(REG_FRAME_HEIGHT, 16'($urandom_range(0, 9)));
                endcase
                must_write = 1'b0;
            end
            tx_pace = ($urandom_range(0, 3) != 0);
            rx_pace = ($urandom_range(0, 3) != 0);
            px  = fill_cols() * fill_rows();
            cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, px - 1) : px;
            // an unfinished frame has to be restarted by a register write
            must_write = (cut != px);
            random_count += queue_frame(cut, $urandom_range(0, 3) == 0);
        end

        // wider frame at streaming rate
        wait_idle();
        tx_pace = 1'b0;
        rx_pace = 1'b0;
        cfg_write(REG_FRAME_WIDTH, 16'd40);
        cfg_write(REG_FRAME_HEIGHT, 16'd4);
        void'(queue_frame(fill_cols() * fill_rows(), 1'b1));

        // oversize width saturates; tallest frame, only the start of its first row is sent
        wait_idle();
        cfg_write(REG_FRAME_WIDTH, 16'd4095);
        cfg_write(REG_FRAME_HEIGHT, 16'd65535);
        void'(queue_frame(30 + $urandom_range(0, 20), 1'b0));

        // short paced frame to end on
        wait_idle();
        tx_pace = 1'b1;
        rx_pace = 1'b1;
        cfg_write(REG_FRAME_WIDTH, 16'd5);
        cfg_write(REG_FRAME_HEIGHT, 16'd4);
        void'(queue_frame(fill_cols() * fill_rows(), 1'b1));
        wait_idle();

        if (fail_count == 0 && filled_due.size() == 0)
            $display("[diagonal_hole_fill] OK");
        else
            $display("[diagonal_hole_fill] ERROR");
        $finish;
    end

endmodule

// File: sim.f
design/dhf_pkg.sv
design/dhf_ram.sv
design/dhf_avg.sv
design/diagonal_hole_fill.sv
design/dhf_checker.sv
test/tb_diagonal_hole_fill.sv
